[hw/rtl/adaptive_pursuit_operator_selector_assert.svh]
// Assertion macros for the operator selector
`ifndef ADAPTIVE_PURSUIT_OPERATOR_SELECTOR_ASSERT_SVH
`define ADAPTIVE_PURSUIT_OPERATOR_SELECTOR_ASSERT_SVH
`ifndef SYNTH
`define APS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define APS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define APS_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define APS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[hw/rtl/aps_pkg.sv]
package aps_pkg;
    localparam int MAX_OPS_DEF      = 8;
    localparam int WINDOW_DEPTH_DEF = 64;
    localparam int SCORE_BITS_DEF   = 24;
    localparam int PROB_BITS        = 17;
    localparam int RESET_PERIOD     = 20;
    localparam int WARMUP_FACTOR    = 5;
    localparam logic [16:0] PROB_ONE = 17'd65536;
    localparam logic CFG_COUNT  = 1'b0;
    localparam logic CFG_LENGTH = 1'b1;

    typedef struct packed {
        logic clear_acc;
        logic write_entry;
        logic scan_entry;
        logic worst_step;
        logic fill_step;
        logic min_step;
        logic reload;
        logic upd_step;
        logic advance;
    } cmd_t;

    typedef struct packed {
        logic warm_done;
        logic rd_last;
        logic op_last;
    } sts_t;
endpackage

[hw/rtl/adaptive_pursuit_operator_selector.sv]
// Adaptive pursuit operator selector.
// Input channel: in_valid/in_stall carries op_index and outcome_score.
// Output channel: out_valid/out_stall carries prob_index, probability and
// last_of_run, one result per operator in use, operator 0 first.
// Configuration: cfg_we, cfg_index, cfg_data; index 0 is operator_count,
// index 1 is window_length. Write only while idle.
// Each request records the outcome, then (after warm-up) scans the window
// one entry per cycle through the window memory read port, runs three passes
// over the operators and one update pass, then emits the results.
// Results are emitted one per cycle while the output is not stalled.
// During warm-up the scan and the passes are skipped.
// The next request is accepted once the last result has been loaded into
// the output register, where it may still be waiting to be taken.
// Reset clears the window valid bits, counters and probabilities to 1/2.
// A stalled output holds its result registers until taken.
module adaptive_pursuit_operator_selector
    import aps_pkg::*;
#(
    parameter int MAX_OPS      = MAX_OPS_DEF,
    parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF,
    parameter int SCORE_BITS   = SCORE_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic                  cfg_index,
    input  logic [6:0]            cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [2:0]            op_index,
    input  logic [SCORE_BITS-1:0] outcome_score,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [2:0]            prob_index,
    output logic [PROB_BITS-1:0]  probability,
    output logic                  last_of_run
);
    `include "adaptive_pursuit_operator_selector_assert.svh"
    localparam int OB = $clog2(MAX_OPS);

    cmd_t cmd;
    sts_t sts;
    logic [OB-1:0] op_sel, n_last;
    logic [PROB_BITS-1:0] prob_w;
    logic busy, emit, in_fire, out_free;
    logic ov_reg;
    logic [2:0] pi_reg;
    logic [PROB_BITS-1:0] pr_reg;
    logic lr_reg;

    assign in_stall = busy;
    assign in_fire = in_valid && !busy;
    assign out_free = !ov_reg || !out_stall;
    assign out_valid = ov_reg;
    assign prob_index = pi_reg;
    assign probability = pr_reg;
    assign last_of_run = lr_reg;

    aps_ctrl #(.MAX_OPS(MAX_OPS)) u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .out_free(out_free),
        .sts(sts), .cmd(cmd), .op_sel(op_sel), .busy(busy), .emit(emit)
    );

    aps_datapath #(
        .MAX_OPS(MAX_OPS), .WINDOW_DEPTH(WINDOW_DEPTH), .SCORE_BITS(SCORE_BITS)
    ) u_dp (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_sel(cfg_index),
        .cfg_data(cfg_data), .op_index(op_index), .outcome_score(outcome_score),
        .cmd(cmd), .op_sel(op_sel), .sts(sts), .n_last(n_last), .prob_out(prob_w)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (out_free)
            ov_reg <= emit;
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            pi_reg <= 3'(op_sel);
            pr_reg <= prob_w;
            lr_reg <= op_sel == n_last;
        end
    end

    `APS_ASSERT_IMPL(a_no_accept_busy, clk, rst_n, busy, !in_fire)
    `APS_ASSERT_NEXT(a_emit_valid, clk, rst_n, emit, out_valid)
    `APS_ASSERT_IMPL(a_idle_no_emit, clk, rst_n, !busy, !emit)
endmodule

[hw/rtl/aps_datapath.sv]
module aps_datapath
    import aps_pkg::*;
#(
    parameter int MAX_OPS      = MAX_OPS_DEF,
    parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF,
    parameter int SCORE_BITS   = SCORE_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic                          cfg_sel,
    input  logic [6:0]                    cfg_data,
    input  logic [2:0]                    op_index,
    input  logic [SCORE_BITS-1:0]         outcome_score,
    input  cmd_t                          cmd,
    input  logic [$clog2(MAX_OPS)-1:0]    op_sel,
    output sts_t                          sts,
    output logic [$clog2(MAX_OPS)-1:0]    n_last,
    output logic [PROB_BITS-1:0]          prob_out
);
    localparam int OB = $clog2(MAX_OPS);
    localparam int WB = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int CB = $clog2(WINDOW_DEPTH + 1);
    localparam int SB = SCORE_BITS + CB;
    localparam int PB = SB + CB;
    localparam int WTB = $clog2(WARMUP_FACTOR * MAX_OPS + 1);
    localparam int UB = PROB_BITS + 6;
    localparam int DIV_SHIFT = 23;
    localparam int MB = UB + 20;
    localparam logic [19:0] DIV10_MUL = 20'd838861;

    logic [3:0] count_reg;
    logic [6:0] length_reg;
    logic [WINDOW_DEPTH-1:0] valid_reg;
    logic [3:0] wop_mem [WINDOW_DEPTH];
    logic [SCORE_BITS-1:0] wsc_mem [WINDOW_DEPTH];
    logic [SB-1:0] sum_reg [MAX_OPS];
    logic [CB-1:0] cnt_reg [MAX_OPS];
    logic [PROB_BITS-1:0] prob_reg [MAX_OPS];
    logic [WB-1:0] slot_reg, rd_reg;
    logic [WTB-1:0] warm_reg;
    logic [4:0] phase_reg;
    logic [SB-1:0] wsum_reg, msum_reg;
    logic [CB-1:0] wcnt_reg, mcnt_reg;
    logic any_reg;
    logic [3:0] rd_op_reg;
    logic [SCORE_BITS-1:0] rd_sc_reg;
    logic rd_ok_reg;
    logic [2:0] op_hold_reg;
    logic [SCORE_BITS-1:0] sc_hold_reg;

    logic [3:0] n_eff;
    logic [CB-1:0] len_eff;
    logic [PROB_BITS-1:0] p_init, pmin, pmax;
    logic [3:0] cfg_n;
    logic [PROB_BITS-1:0] cfg_prob;
    logic [SB-1:0] s_o;
    logic [CB-1:0] c_o;
    logic [PB-1:0] lhs_w, rhs_w, lhs_m, rhs_m;
    logic [UB-1:0] upd_sum;
    logic [MB-1:0] upd_prod;
    logic [PROB_BITS-1:0] tgt, upd_val;

    always_comb
    begin
        n_eff = count_reg;
        if (count_reg < 4'd2) n_eff = 4'd2;
        else if (int'(count_reg) > MAX_OPS) n_eff = 4'(MAX_OPS);
        len_eff = CB'(length_reg);
        if (length_reg == 7'd0) len_eff = CB'(1);
        else if (int'(length_reg) > WINDOW_DEPTH) len_eff = CB'(WINDOW_DEPTH);
    end
    assign n_last = OB'(n_eff - 4'd1);

    always_comb
    begin
        p_init = 17'd32768;
        pmin = 17'd6553;
        case (n_eff)
            4'd3: begin p_init = 17'd21845; pmin = 17'd4369; end
            4'd4: begin p_init = 17'd16384; pmin = 17'd3276; end
            4'd5: begin p_init = 17'd13107; pmin = 17'd2621; end
            4'd6: begin p_init = 17'd10922; pmin = 17'd2184; end
            4'd7: begin p_init = 17'd9362;  pmin = 17'd1872; end
            4'd8: begin p_init = 17'd8192;  pmin = 17'd1638; end
            default: begin p_init = 17'd32768; pmin = 17'd6553; end
        endcase
        pmax = PROB_BITS'(PROB_ONE - PROB_BITS'((n_eff - 4'd1) * pmin));
    end

    always_comb
    begin
        cfg_n = cfg_data[3:0];
        if (cfg_data[3:0] < 4'd2) cfg_n = 4'd2;
        else if (int'(cfg_data[3:0]) > MAX_OPS) cfg_n = 4'(MAX_OPS);
        case (cfg_n)
            4'd3: cfg_prob = 17'd21845;
            4'd4: cfg_prob = 17'd16384;
            4'd5: cfg_prob = 17'd13107;
            4'd6: cfg_prob = 17'd10922;
            4'd7: cfg_prob = 17'd9362;
            4'd8: cfg_prob = 17'd8192;
            default: cfg_prob = 17'd32768;
        endcase
    end

    assign s_o = sum_reg[op_sel];
    assign c_o = cnt_reg[op_sel];
    assign lhs_w = PB'(s_o) * PB'(wcnt_reg);
    assign rhs_w = PB'(wsum_reg) * PB'(c_o);
    assign lhs_m = PB'(s_o) * PB'(mcnt_reg);
    assign rhs_m = PB'(msum_reg) * PB'(c_o);
    assign tgt = (lhs_m == rhs_m) ? pmax : pmin;
    assign upd_sum = UB'(3) * UB'(prob_reg[op_sel]) + UB'(7) * UB'(tgt) + UB'(5);
    // divide by ten: reciprocal multiply, exact for sums below 2^22
    assign upd_prod = MB'(upd_sum) * MB'(DIV10_MUL);
    assign upd_val = upd_prod[DIV_SHIFT+PROB_BITS-1:DIV_SHIFT];

    assign sts.warm_done = int'(warm_reg) >= WARMUP_FACTOR * int'(n_eff);
    assign sts.rd_last = (CB'(rd_reg) + CB'(1)) >= len_eff;
    assign sts.op_last = op_sel == n_last;
    assign prob_out = prob_reg[op_sel];

    always_ff @(posedge clk)
    begin
        if (cmd.write_entry && {1'b0, op_hold_reg} < n_eff)
        begin
            wop_mem[slot_reg] <= {1'b0, op_hold_reg};
            wsc_mem[slot_reg] <= sc_hold_reg;
        end
        rd_op_reg <= wop_mem[rd_reg];
        rd_sc_reg <= wsc_mem[rd_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 4'd2;
            length_reg <= 7'd64;
            valid_reg <= '0;
            slot_reg <= '0;
            rd_reg <= '0;
            warm_reg <= '0;
            phase_reg <= '0;
            rd_ok_reg <= 1'b0;
            any_reg <= 1'b0;
            wsum_reg <= '0;
            wcnt_reg <= CB'(1);
            msum_reg <= '0;
            mcnt_reg <= '0;
            op_hold_reg <= '0;
            sc_hold_reg <= '0;
            for (int i = 0; i < MAX_OPS; i++)
            begin
                prob_reg[i] <= 17'd32768;
                sum_reg[i] <= '0;
                cnt_reg[i] <= '0;
            end
        end
        else
        begin
            rd_ok_reg <= cmd.scan_entry && valid_reg[rd_reg];
            if (cfg_we && cfg_sel == CFG_COUNT)
            begin
                count_reg <= cfg_data[3:0];
                for (int i = 0; i < MAX_OPS; i++)
                    prob_reg[i] <= cfg_prob;
            end
            if (cfg_we && cfg_sel == CFG_LENGTH)
            begin
                length_reg <= cfg_data;
                valid_reg <= '0;
                slot_reg <= '0;
            end
            if (cmd.clear_acc)
            begin
                if (CB'(slot_reg) >= len_eff) slot_reg <= '0;
                op_hold_reg <= op_index;
                sc_hold_reg <= outcome_score;
                rd_reg <= '0;
                any_reg <= 1'b0;
                wsum_reg <= '0;
                wcnt_reg <= CB'(1);
                for (int i = 0; i < MAX_OPS; i++)
                begin
                    sum_reg[i] <= '0;
                    cnt_reg[i] <= '0;
                end
            end
            if (cmd.write_entry && {1'b0, op_hold_reg} < n_eff)
                valid_reg[slot_reg] <= 1'b1;
            if (cmd.scan_entry)
                rd_reg <= WB'(rd_reg + WB'(1));
            if (rd_ok_reg && rd_op_reg < n_eff)
            begin
                sum_reg[rd_op_reg[OB-1:0]] <= sum_reg[rd_op_reg[OB-1:0]] + SB'(rd_sc_reg);
                cnt_reg[rd_op_reg[OB-1:0]] <= cnt_reg[rd_op_reg[OB-1:0]] + CB'(1);
            end
            if (cmd.worst_step && c_o != '0)
            begin
                if (!any_reg || lhs_w > rhs_w)
                begin
                    wsum_reg <= s_o;
                    wcnt_reg <= c_o;
                end
                any_reg <= 1'b1;
            end
            if (cmd.fill_step && c_o == '0)
            begin
                sum_reg[op_sel] <= wsum_reg;
                cnt_reg[op_sel] <= wcnt_reg;
            end
            if (cmd.min_step && (op_sel == '0 || lhs_m < rhs_m))
            begin
                msum_reg <= s_o;
                mcnt_reg <= c_o;
            end
            if (cmd.reload && phase_reg == 5'd0)
                for (int i = 0; i < MAX_OPS; i++)
                    prob_reg[i] <= p_init;
            if (cmd.upd_step)
                prob_reg[op_sel] <= upd_val;
            if (cmd.advance)
            begin
                if (CB'(slot_reg) + CB'(1) >= len_eff) slot_reg <= '0;
                else slot_reg <= WB'(slot_reg + WB'(1));
                if (!sts.warm_done) warm_reg <= WTB'(warm_reg + WTB'(1));
                phase_reg <= (phase_reg == 5'(RESET_PERIOD - 1)) ? 5'd0 : 5'(phase_reg + 5'd1);
            end
        end
    end
endmodule

[hw/rtl/aps_ctrl.sv]
module aps_ctrl
    import aps_pkg::*;
#(
    parameter int MAX_OPS = MAX_OPS_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_fire,
    input  logic                       out_free,
    input  sts_t                       sts,
    output cmd_t                       cmd,
    output logic [$clog2(MAX_OPS)-1:0] op_sel,
    output logic                       busy,
    output logic                       emit
);
    localparam int OB = $clog2(MAX_OPS);
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_WRITE = 4'd1;
    localparam logic [3:0] S_SCAN  = 4'd2;
    localparam logic [3:0] S_DRAIN = 4'd3;
    localparam logic [3:0] S_WORST = 4'd4;
    localparam logic [3:0] S_FILL  = 4'd5;
    localparam logic [3:0] S_MIN   = 4'd6;
    localparam logic [3:0] S_UPD   = 4'd7;
    localparam logic [3:0] S_EMIT  = 4'd8;
    localparam logic [3:0] S_RELOAD = 4'd9;

    logic [3:0] state_reg, state_next;
    logic [OB-1:0] sel_reg, sel_next;
    logic warm_reg, warm_next;

    assign op_sel = sel_reg;
    assign busy = state_reg != S_IDLE;
    assign emit = state_reg == S_EMIT && out_free;

    always_comb
    begin
        state_next = state_reg;
        sel_next = sel_reg;
        warm_next = warm_reg;
        cmd = '0;
        case (state_reg)
            S_IDLE:
                if (in_fire)
                begin
                    cmd.clear_acc = 1'b1;
                    warm_next = sts.warm_done;
                    state_next = S_WRITE;
                end
            S_WRITE:
            begin
                cmd.write_entry = 1'b1;
                state_next = warm_reg ? S_RELOAD : S_EMIT;
                sel_next = '0;
            end
            S_RELOAD:
            begin
                cmd.reload = 1'b1;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                cmd.scan_entry = 1'b1;
                if (sts.rd_last) state_next = S_DRAIN;
            end
            S_DRAIN:
            begin
                sel_next = '0;
                state_next = S_WORST;
            end
            S_WORST:
            begin
                cmd.worst_step = 1'b1;
                sel_next = sts.op_last ? '0 : OB'(sel_reg + OB'(1));
                if (sts.op_last) state_next = S_FILL;
            end
            S_FILL:
            begin
                cmd.fill_step = 1'b1;
                sel_next = sts.op_last ? '0 : OB'(sel_reg + OB'(1));
                if (sts.op_last) state_next = S_MIN;
            end
            S_MIN:
            begin
                cmd.min_step = 1'b1;
                sel_next = sts.op_last ? '0 : OB'(sel_reg + OB'(1));
                if (sts.op_last) state_next = S_UPD;
            end
            S_UPD:
            begin
                cmd.upd_step = 1'b1;
                sel_next = sts.op_last ? '0 : OB'(sel_reg + OB'(1));
                if (sts.op_last) state_next = S_EMIT;
            end
            S_EMIT:
                if (out_free)
                begin
                    if (sel_reg == '0) cmd.advance = 1'b1;
                    sel_next = sts.op_last ? '0 : OB'(sel_reg + OB'(1));
                    if (sts.op_last) state_next = S_IDLE;
                end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            sel_reg <= '0;
            warm_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            sel_reg <= sel_next;
            warm_reg <= warm_next;
        end
    end
endmodule
